// ===== hw/rtl/sds_pkg.sv =====
// ----------------------------------------------------------------------------
// sds_pkg
// shared types, constants and helpers for the sheet dispense sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package sds_pkg;

    // width of the interval countdown, loads above its range saturate
    localparam int TIMER_WIDTH = 24;
    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_WIDTH) - 64'd1);

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 24;
    localparam int IN_TDATA_WIDTH  = 24;
    localparam int OUT_TDATA_WIDTH = 24;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_HALF_PERIOD = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEP_GAP    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_STEPS       = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PAUSE       = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RAMP        = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_POLL        = 3'd5;

    // input opcodes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_HOME  = 8'b0000_0010,
        PH_SHEET = 8'b0000_0100,
        PH_HIGH  = 8'b0000_1000,
        PH_LOW   = 8'b0001_0000,
        PH_GAP   = 8'b0010_0000,
        PH_PAUSE = 8'b0100_0000,
        PH_RAMP  = 8'b1000_0000
    } sds_phase_t;

    typedef struct packed {
        logic [15:0] half_period_ticks;
        logic [15:0] step_gap_ticks;
        logic [15:0] steps_per_paper;
        logic [23:0] paper_pause_ticks;
        logic [23:0] ramp_ticks;
        logic [23:0] poll_ticks;
    } sds_cfg_t;

    typedef struct packed {
        logic [15:0] sheets_done;
        logic        busy_res;
        logic        motor_reverse;
        logic        motor_forward;
        logic        step_dir;
        logic        step_pulse;
    } sds_res_t;

    // saturating load of a register value into the countdown
    function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [23:0] value);
        logic [31:0] wide;
        wide = {8'd0, value};
        if (wide > TIMER_MAX)
        begin
            return TIMER_MAX[TIMER_WIDTH-1:0];
        end
        return wide[TIMER_WIDTH-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/sheet_dispense_sequencer.sv =====
// ----------------------------------------------------------------------------
// sheet_dispense_sequencer
// homes the feed on a limit switch, steps out sheets and ramps the motor back
// ----------------------------------------------------------------------------
// Each input word is either a 1 us tick (tuser low) or a start command (tuser
// high); every accepted word yields exactly one result word holding the line
// levels after that word's update. One word is taken per clock cycle while the
// output buffer has room: the whole update is a single pass of next-state logic
// from the state registers, and its result is written into a two-word output
// buffer at the accepting edge, from where it leaves in order.
// s_tready only drops while both buffer words wait on the output side, so a
// stalled consumer never costs throughput until the buffer is full. The
// configuration channel is always ready and should be written while no result
// is pending; a write takes effect the next time that value is loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sheet_dispense_sequencer (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // input stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] paper_count, [16] limit_pressed, [23:17] zero
    input  wire logic [sds_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
    // [0] opcode
    input  wire logic                                s_tuser,
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [0] step_pulse, [1] step_dir, [2] motor_forward, [3] motor_reverse,
    // [4] busy_res, [20:5] sheets_done, [23:21] zero
    output logic [sds_pkg::OUT_TDATA_WIDTH-1:0]      m_tdata,
    // configuration writes
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sds_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [sds_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
    import sds_pkg::*;

    sds_cfg_t cfg;
    sds_res_t res_next;
    sds_res_t res_out;
    logic     has_room;
    logic     item_en;

    // a word is taken whenever the output buffer has a free slot
    assign s_tready = has_room;
    assign item_en  = s_tvalid && has_room;

    sds_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // sequencer state advances once per accepted word
    sds_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item_en       (item_en),
        .opcode        (s_tuser),
        .paper_count   (s_tdata[15:0]),
        .limit_pressed (s_tdata[16]),
        .res_next      (res_next)
    );

    sds_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (item_en),
        .push_data (res_next),
        .has_room  (has_room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (res_out)
    );

    // pack the result word, step_pulse in bit 0 and zero padding on top
    assign m_tdata = {3'd0, res_out.sheets_done, res_out.busy_res, res_out.motor_reverse,
                      res_out.motor_forward, res_out.step_dir, res_out.step_pulse};

endmodule

`default_nettype wire

// ===== hw/rtl/sds_cfg.sv =====
// ----------------------------------------------------------------------------
// sds_cfg
// configuration register file, one write per handshake
// ----------------------------------------------------------------------------
`default_nettype none

module sds_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [sds_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [sds_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    output sds_pkg::sds_cfg_t                        cfg
);
    import sds_pkg::*;

    sds_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= 16'd1000;
            cfg_reg.step_gap_ticks    <= 16'd1000;
            cfg_reg.steps_per_paper   <= 16'd200;
            cfg_reg.paper_pause_ticks <= 24'd100000;
            cfg_reg.ramp_ticks        <= 24'd8000000;
            cfg_reg.poll_ticks        <= 24'd100000;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_HALF_PERIOD: cfg_reg.half_period_ticks <= cfg_data[15:0];
                REG_STEP_GAP:    cfg_reg.step_gap_ticks    <= cfg_data[15:0];
                REG_STEPS:       cfg_reg.steps_per_paper   <= cfg_data[15:0];
                REG_PAUSE:       cfg_reg.paper_pause_ticks <= cfg_data;
                REG_RAMP:        cfg_reg.ramp_ticks        <= cfg_data;
                REG_POLL:        cfg_reg.poll_ticks        <= cfg_data;
                default:         ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sds_core.sv =====
// ----------------------------------------------------------------------------
// sds_core
// sequencer state and single-pass next-state logic, one item per cycle while item_en is high
// ----------------------------------------------------------------------------
`default_nettype none

module sds_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  sds_pkg::sds_cfg_t      cfg,
    input  wire logic              item_en,
    input  wire logic              opcode,
    input  wire logic [15:0]       paper_count,
    input  wire logic              limit_pressed,
    output sds_pkg::sds_res_t      res_next
);
    import sds_pkg::*;

    sds_phase_t             phase_reg,        phase_next;
    logic [TIMER_WIDTH-1:0] countdown_reg,    countdown_next;
    logic [15:0]            steps_left_reg,   steps_left_next;
    logic [15:0]            sheets_left_reg,  sheets_left_next;
    logic [15:0]            sheets_count_reg, sheets_count_next;
    logic                   pulse_reg,        pulse_next;
    logic                   dir_reg,          dir_next;
    logic                   fwd_reg,          fwd_next;
    logic                   rev_reg,          rev_next;
    logic [15:0]            steps_dec;

    assign steps_dec = steps_left_reg - 16'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        countdown_next    = countdown_reg;
        steps_left_next   = steps_left_reg;
        sheets_left_next  = sheets_left_reg;
        sheets_count_next = sheets_count_reg;
        pulse_next        = pulse_reg;
        dir_next          = dir_reg;
        fwd_next          = fwd_reg;
        rev_next          = rev_reg;

        if (opcode == OP_START)
        begin
            if (phase_reg == PH_IDLE)
            begin
                sheets_left_next  = paper_count;
                sheets_count_next = 16'd0;
                steps_left_next   = 16'd0;
                countdown_next    = '0;
                fwd_next          = 1'b1;
                rev_next          = 1'b0;
                phase_next        = PH_HOME;
            end
        end
        else if (phase_reg != PH_IDLE)
        begin
            if (countdown_reg > TIMER_WIDTH'(1))
            begin
                countdown_next = countdown_reg - TIMER_WIDTH'(1);
            end
            else
            begin
                case (phase_reg)
                    PH_HOME:
                    begin
                        if (limit_pressed)
                        begin
                            fwd_next       = 1'b0;
                            countdown_next = '0;
                            phase_next     = PH_SHEET;
                        end
                        else
                        begin
                            countdown_next = timer_load(cfg.poll_ticks);
                        end
                    end
                    PH_SHEET:
                    begin
                        if (sheets_left_reg == 16'd0)
                        begin
                            fwd_next       = 1'b0;
                            rev_next       = 1'b1;
                            countdown_next = timer_load(cfg.ramp_ticks);
                            phase_next     = PH_RAMP;
                        end
                        else if (!limit_pressed)
                        begin
                            fwd_next       = 1'b1;
                            rev_next       = 1'b0;
                            countdown_next = '0;
                            phase_next     = PH_HOME;
                        end
                        else
                        begin
                            dir_next        = 1'b1;
                            steps_left_next = cfg.steps_per_paper;
                            if (cfg.steps_per_paper == 16'd0)
                            begin
                                sheets_left_next  = sheets_left_reg - 16'd1;
                                sheets_count_next = sheets_count_reg + 16'd1;
                                countdown_next    = timer_load(cfg.paper_pause_ticks);
                                phase_next        = PH_PAUSE;
                            end
                            else
                            begin
                                pulse_next     = 1'b1;
                                countdown_next = timer_load({8'd0, cfg.half_period_ticks});
                                phase_next     = PH_HIGH;
                            end
                        end
                    end
                    PH_HIGH:
                    begin
                        pulse_next     = 1'b0;
                        countdown_next = timer_load({8'd0, cfg.half_period_ticks});
                        phase_next     = PH_LOW;
                    end
                    PH_LOW:
                    begin
                        countdown_next = timer_load({8'd0, cfg.step_gap_ticks});
                        phase_next     = PH_GAP;
                    end
                    PH_GAP:
                    begin
                        steps_left_next = steps_dec;
                        if (steps_dec != 16'd0)
                        begin
                            pulse_next     = 1'b1;
                            countdown_next = timer_load({8'd0, cfg.half_period_ticks});
                            phase_next     = PH_HIGH;
                        end
                        else
                        begin
                            sheets_left_next  = sheets_left_reg - 16'd1;
                            sheets_count_next = sheets_count_reg + 16'd1;
                            countdown_next    = timer_load(cfg.paper_pause_ticks);
                            phase_next        = PH_PAUSE;
                        end
                    end
                    PH_PAUSE:
                    begin
                        countdown_next = '0;
                        phase_next     = PH_SHEET;
                    end
                    PH_RAMP:
                    begin
                        rev_next       = 1'b0;
                        countdown_next = '0;
                        phase_next     = PH_IDLE;
                    end
                    default:
                    begin
                        phase_next = phase_reg;
                    end
                endcase
            end
        end
    end

    // the result is the line levels after this item's update
    assign res_next.step_pulse    = pulse_next;
    assign res_next.step_dir      = dir_next;
    assign res_next.motor_forward = fwd_next;
    assign res_next.motor_reverse = rev_next;
    assign res_next.busy_res      = (phase_next != PH_IDLE);
    assign res_next.sheets_done   = sheets_count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            countdown_reg    <= '0;
            steps_left_reg   <= 16'd0;
            sheets_left_reg  <= 16'd0;
            sheets_count_reg <= 16'd0;
            pulse_reg        <= 1'b0;
            dir_reg          <= 1'b0;
            fwd_reg          <= 1'b0;
            rev_reg          <= 1'b0;
        end
        else if (item_en)
        begin
            phase_reg        <= phase_next;
            countdown_reg    <= countdown_next;
            steps_left_reg   <= steps_left_next;
            sheets_left_reg  <= sheets_left_next;
            sheets_count_reg <= sheets_count_next;
            pulse_reg        <= pulse_next;
            dir_reg          <= dir_next;
            fwd_reg          <= fwd_next;
            rev_reg          <= rev_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sds_outbuf.sv =====
// ----------------------------------------------------------------------------
// sds_outbuf
// two-word result buffer, decouples output stalls from input acceptance
// ----------------------------------------------------------------------------
`default_nettype none

module sds_outbuf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  sds_pkg::sds_res_t  push_data,
    output logic               has_room,
    output logic               out_valid,
    input  wire logic          out_ready,
    output sds_pkg::sds_res_t  out_data
);
    import sds_pkg::*;

    sds_res_t    head_reg, head_next;
    sds_res_t    skid_reg, skid_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign out_data  = head_reg;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        head_next  = head_reg;
        skid_next  = skid_reg;
        count_next = count_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    head_next  = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    head_next = push_data;
                end
                else if (push)
                begin
                    skid_next  = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    head_next  = skid_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sds_checker.sv =====
// ----------------------------------------------------------------------------
// sds_checker
// port-level checks on the result stream of the sheet dispense sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module sds_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tready,
    input  wire logic                                m_tvalid,
    input  wire logic                                m_tready,
    input  wire logic [sds_pkg::OUT_TDATA_WIDTH-1:0] m_tdata
);
    import sds_pkg::*;

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // the bridge is never driven both ways
    a_bridge: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[2] && m_tdata[3]))
        else $error("feed motor driven forward and reverse at once");

    // when idle the feed motor is off and the pulse line is low
    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[4] |-> !m_tdata[0] && !m_tdata[2] && !m_tdata[3])
        else $error("lines active while idle");

    // once stepping began the direction line stays high
    a_dir_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata[1] ##1 m_tvalid |-> m_tdata[1])
        else $error("direction line dropped");

    // a stalled input with the buffer full holds ready low until a result goes
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready && !(m_tvalid && m_tready) |=> !s_tready)
        else $error("input ready rose without a result leaving");

endmodule

bind sheet_dispense_sequencer sds_checker u_sds_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/tb_sheet_dispense_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_sheet_dispense_sequencer
// self-checking bench for the sheet dispense sequencer
// ----------------------------------------------------------------------------
// A short table of directed words (reset levels, zero sheets, start while
// busy, a second homing pass, zero steps per sheet) is walked first, then
// randomised dispense sequences under random settings, then a run with the
// counts at the top and a run under a long result hold-off. Every accepted
// input word is pushed through a local model of the sequencer and the
// expected line levels are queued; each result word is compared field by
// field with the oldest entry. Both sides idle at random, the result side
// holds off once for a long stretch, and a watchdog ends the run if no word
// moves for too long.
// ----------------------------------------------------------------------------

module tb_sheet_dispense_sequencer;

    timeunit 1ns;
    timeprecision 1ps;

    import sds_pkg::*;

    // cycles with no word on any channel before the run is abandoned
    localparam int QUIET_LIMIT   = 4000;
    // length of the one long hold-off on the result side
    localparam int HOLD_CYCLES   = 300;
    // random words wanted before the extreme runs
    localparam int RANDOM_WORDS  = 1100;
    localparam int REPORT_LIMIT  = 10;

    // indexes past the last register, writes there must change nothing
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_HI = 3'd7;

    // one row of the directed table: either a register write or a word
    typedef struct packed {
        logic                       is_cfg;
        logic [CFG_INDEX_WIDTH-1:0] idx;
        logic [CFG_DATA_WIDTH-1:0]  data;
        logic                       op;
        logic [15:0]                count;
        logic                       pressed;
        logic                       typed;
        sds_res_t                   want;
    } plan_row_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        s_tvalid  = 1'b0;
    logic                        s_tready;
    logic [IN_TDATA_WIDTH-1:0]   s_tdata   = '0;
    logic                        s_tuser   = 1'b0;
    logic                        m_tvalid;
    logic                        m_tready  = 1'b0;
    logic [OUT_TDATA_WIDTH-1:0]  m_tdata;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data  = '0;

    // expected line levels, oldest first
    sds_res_t  levels_due[$];
    plan_row_t plan[$];

    int  fail_count  = 0;
    int  work_words  = 0;
    bit  calm        = 1'b0;   // no idling on either side while set
    bit  stall_req   = 1'b0;   // asks the result side for one long hold-off
    bit  offering    = 1'b0;   // mirrors s_tvalid as last driven
    bit  cfg_on      = 1'b0;   // mirrors cfg_valid as last driven

    // local copy of the registers
    logic [15:0] set_half;
    logic [15:0] set_gap;
    logic [15:0] set_steps;
    logic [23:0] set_pause;
    logic [23:0] set_ramp;
    logic [23:0] set_poll;

    // local copy of the sequencer state
    sds_phase_t             seq_phase;
    logic [TIMER_WIDTH-1:0] seq_timer;
    logic [15:0]            seq_steps_left;
    logic [15:0]            seq_sheets_left;
    logic [15:0]            seq_sheets_done;
    logic                   seq_pulse;
    logic                   seq_dir;
    logic                   seq_fwd;
    logic                   seq_rev;

    sheet_dispense_sequencer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------------
    // sequencer model
    // ------------------------------------------------------------------------

    // interval loads clip at the top of the countdown range
    function automatic logic [TIMER_WIDTH-1:0] clip_interval(input logic [23:0] ticks);
        logic [31:0] wide;
        wide = 32'(ticks);
        if (wide > TIMER_MAX)
        begin
            wide = TIMER_MAX;
        end
        return wide[TIMER_WIDTH-1:0];
    endfunction

    function automatic void model_reset();
        set_half        = 16'd1000;
        set_gap         = 16'd1000;
        set_steps       = 16'd200;
        set_pause       = 24'd100000;
        set_ramp        = 24'd8000000;
        set_poll        = 24'd100000;
        seq_phase       = PH_IDLE;
        seq_timer       = '0;
        seq_steps_left  = '0;
        seq_sheets_left = '0;
        seq_sheets_done = '0;
        seq_pulse       = 1'b0;
        seq_dir         = 1'b0;
        seq_fwd         = 1'b0;
        seq_rev         = 1'b0;
    endfunction

    function automatic void model_write(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                        input logic [CFG_DATA_WIDTH-1:0] data);
        case (idx)
            REG_HALF_PERIOD: set_half  = data[15:0];
            REG_STEP_GAP:    set_gap   = data[15:0];
            REG_STEPS:       set_steps = data[15:0];
            REG_PAUSE:       set_pause = data[23:0];
            REG_RAMP:        set_ramp  = data[23:0];
            REG_POLL:        set_poll  = data[23:0];
            default:         ;
        endcase
    endfunction

    function automatic void raise_pulse();
        seq_pulse = 1'b1;
        seq_timer = clip_interval(24'(set_half));
        seq_phase = PH_HIGH;
    endfunction

    // end of a sheet (last gap, or zero steps): count it and start the pause
    function automatic void close_sheet();
        seq_sheets_left = seq_sheets_left - 16'd1;
        seq_sheets_done = seq_sheets_done + 16'd1;
        seq_timer       = clip_interval(set_pause);
        seq_phase       = PH_PAUSE;
    endfunction

    // what a phase does once its interval has run out
    function automatic void phase_expired(input logic pressed);
        case (seq_phase)
            PH_HOME:
            begin
                if (pressed)
                begin
                    seq_fwd   = 1'b0;
                    seq_timer = '0;
                    seq_phase = PH_SHEET;
                end
                else
                begin
                    seq_timer = clip_interval(set_poll);
                end
            end
            PH_SHEET:
            begin
                if (seq_sheets_left == 16'd0)
                begin
                    seq_fwd   = 1'b0;
                    seq_rev   = 1'b1;
                    seq_timer = clip_interval(set_ramp);
                    seq_phase = PH_RAMP;
                end
                else if (!pressed)
                begin
                    // switch let go during the pause: home again
                    seq_fwd   = 1'b1;
                    seq_rev   = 1'b0;
                    seq_timer = '0;
                    seq_phase = PH_HOME;
                end
                else
                begin
                    seq_dir        = 1'b1;
                    seq_steps_left = set_steps;
                    if (seq_steps_left == 16'd0)
                    begin
                        close_sheet();
                    end
                    else
                    begin
                        raise_pulse();
                    end
                end
            end
            PH_HIGH:
            begin
                seq_pulse = 1'b0;
                seq_timer = clip_interval(24'(set_half));
                seq_phase = PH_LOW;
            end
            PH_LOW:
            begin
                seq_timer = clip_interval(24'(set_gap));
                seq_phase = PH_GAP;
            end
            PH_GAP:
            begin
                seq_steps_left = seq_steps_left - 16'd1;
                if (seq_steps_left != 16'd0)
                begin
                    raise_pulse();
                end
                else
                begin
                    close_sheet();
                end
            end
            PH_PAUSE:
            begin
                seq_timer = '0;
                seq_phase = PH_SHEET;
            end
            PH_RAMP:
            begin
                seq_rev   = 1'b0;
                seq_timer = '0;
                seq_phase = PH_IDLE;
            end
            default: ;
        endcase
    endfunction

    // advance the model by one word and return the line levels it leaves
    function automatic sds_res_t dispense_levels(input logic op, input logic [15:0] count,
                                                 input logic pressed);
        sds_res_t lv;
        if (op == OP_START)
        begin
            // a start while busy is dropped and is not a tick either
            if (seq_phase == PH_IDLE)
            begin
                seq_sheets_left = count;
                seq_sheets_done = '0;
                seq_steps_left  = '0;
                seq_timer       = '0;
                seq_fwd         = 1'b1;
                seq_rev         = 1'b0;
                seq_phase       = PH_HOME;
            end
        end
        else if (seq_phase != PH_IDLE)
        begin
            if (seq_timer > 1)
            begin
                seq_timer = seq_timer - 1'b1;
            end
            else
            begin
                phase_expired(pressed);
            end
        end
        lv.step_pulse    = seq_pulse;
        lv.step_dir      = seq_dir;
        lv.motor_forward = seq_fwd;
        lv.motor_reverse = seq_rev;
        lv.busy_res      = (seq_phase != PH_IDLE);
        lv.sheets_done   = seq_sheets_done;
        return lv;
    endfunction

    function automatic sds_res_t levels(input logic pulse, input logic dir, input logic fwd,
                                        input logic rev, input logic busy,
                                        input logic [15:0] sheets);
        sds_res_t lv;
        lv.step_pulse    = pulse;
        lv.step_dir      = dir;
        lv.motor_forward = fwd;
        lv.motor_reverse = rev;
        lv.busy_res      = busy;
        lv.sheets_done   = sheets;
        return lv;
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // offer one word, wait for it to be taken, then queue its expected levels
    task automatic send_word(input logic op, input logic [15:0] count, input logic pressed,
                             input logic typed, input sds_res_t want);
        sds_res_t predicted;
        if (cfg_on)
        begin
            cfg_valid <= 1'b0;
            cfg_on = 1'b0;
        end
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 30)
            begin
                if (offering)
                begin
                    s_tvalid <= 1'b0;
                    offering = 1'b0;
                end
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        offering = 1'b1;
        s_tdata  <= {7'd0, pressed, count};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predicted = dispense_levels(op, count, pressed);
        levels_due.push_back(typed ? want : predicted);
    endtask

    // stop offering and wait until every queued word has come back
    task automatic settle();
        if (offering)
        begin
            s_tvalid <= 1'b0;
            offering = 1'b0;
        end
        while (levels_due.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // only called while the block is idle and nothing is queued
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_on = 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        model_write(idx, data);
    endtask

    // one dispense from start to idle, ticks carry random junk in the count
    task automatic run_sequence(input logic [15:0] sheets, input int release_pct);
        send_word(OP_START, sheets, 1'($urandom), 1'b0, '0);
        work_words++;
        while (seq_phase != PH_IDLE)
        begin
            if ($urandom_range(0, 99) < 5)
            begin
                // start while busy, dropped by the block
                send_word(OP_START, 16'($urandom), 1'($urandom), 1'b0, '0);
            end
            else
            begin
                send_word(OP_TICK, 16'($urandom),
                          ($urandom_range(0, 99) >= release_pct), 1'b0, '0);
                work_words++;
            end
        end
    endtask

    function automatic void add_cfg(input logic [CFG_INDEX_WIDTH-1:0] idx,
                                    input logic [CFG_DATA_WIDTH-1:0] data);
        plan_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.data   = data;
        plan.push_back(row);
    endfunction

    function automatic void add_word(input logic op, input logic [15:0] count,
                                     input logic pressed);
        plan_row_t row;
        row         = '0;
        row.op      = op;
        row.count   = count;
        row.pressed = pressed;
        plan.push_back(row);
    endfunction

    function automatic void add_typed(input logic op, input logic [15:0] count,
                                      input logic pressed, input sds_res_t want);
        plan_row_t row;
        row         = '0;
        row.op      = op;
        row.count   = count;
        row.pressed = pressed;
        row.typed   = 1'b1;
        row.want    = want;
        plan.push_back(row);
    endfunction

    // ------------------------------------------------------------------------
    // result side: random ready, one long hold-off on request, checking
    // ------------------------------------------------------------------------

    task automatic check_word(input logic [OUT_TDATA_WIDTH-1:0] word);
        sds_res_t got;
        sds_res_t want;
        logic [2:0] pad;
        got = sds_res_t'(word[20:0]);
        pad = word[23:21];
        if (levels_due.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
            begin
                $display("result word 0x%06h with nothing expected", word);
            end
        end
        else
        begin
            want = levels_due.pop_front();
            if (got.step_pulse !== want.step_pulse || got.step_dir !== want.step_dir ||
                got.motor_forward !== want.motor_forward ||
                got.motor_reverse !== want.motor_reverse ||
                got.busy_res !== want.busy_res || got.sheets_done !== want.sheets_done ||
                pad !== 3'd0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("mismatch at %0t: expected pulse %0b dir %0b fwd %0b rev %0b",
                             $realtime, want.step_pulse, want.step_dir,
                             want.motor_forward, want.motor_reverse);
                    $display("    busy %0b sheets %0d pad 0; got pulse %0b dir %0b fwd %0b",
                             want.busy_res, want.sheets_done, got.step_pulse,
                             got.step_dir, got.motor_forward);
                    $display("    rev %0b busy %0b sheets %0d pad %0d",
                             got.motor_reverse, got.busy_res, got.sheets_done, pad);
                end
            end
        end
    endtask

    initial
    begin : result_side
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                check_word(m_tdata);
            end
            if (stall_req)
            begin
                stall_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
            end
        end
    end

    // watchdog: no word on any channel for too long means the block hung
    always @(posedge clk)
    begin : watchdog
        int quiet;
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet = quiet + 1;
        end
        if (quiet >= QUIET_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin : stimulus
        int rows;
        model_reset();

        // reset levels and the zero sheet case under the reset settings,
        // with the ramp cut short so the sequence ends
        add_typed(OP_TICK, 16'h0000, 1'b0,
                  levels(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        add_typed(OP_TICK, 16'hFFFF, 1'b1,
                  levels(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));
        add_cfg(REG_RAMP, 24'd1);
        add_typed(OP_START, 16'h0000, 1'b0,
                  levels(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
        // start while busy is dropped
        add_typed(OP_START, 16'hFFFF, 1'b1,
                  levels(1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 16'd0));
        // switch hit on the first sample stops the motor
        add_typed(OP_TICK, 16'h0000, 1'b1,
                  levels(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 16'd0));
        // no sheets left: straight to the reverse ramp
        add_typed(OP_TICK, 16'h0000, 1'b0,
                  levels(1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 16'd0));
        add_typed(OP_TICK, 16'h0000, 1'b0,
                  levels(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 16'd0));

        // shortest timers, junk in the bits above the 16 bit registers
        add_cfg(REG_HALF_PERIOD, 24'hFF0000);
        add_cfg(REG_STEP_GAP,    24'h000000);
        add_cfg(REG_STEPS,       24'hFF0001);
        add_cfg(REG_PAUSE,       24'd0);
        add_cfg(REG_RAMP,        24'd0);
        add_cfg(REG_POLL,        24'd1);
        add_cfg(REG_SPARE_LO,    24'hFFFFFF);
        add_cfg(REG_SPARE_HI,    24'h5A5A5A);

        // one sheet: a poll miss, a hit, a release in the sheet check and a
        // second homing pass, then one pulse, the pause and the ramp
        add_word(OP_START, 16'd1, 1'b0);
        add_word(OP_TICK,  16'd0, 1'b0);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b0);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);

        // zero steps per sheet: the sheet goes straight to its pause
        add_cfg(REG_STEPS, 24'd0);
        add_word(OP_START, 16'd1, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);
        add_word(OP_TICK,  16'd0, 1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = plan.size();
        for (int i = 0; i < rows; i++)
        begin
            if (plan[i].is_cfg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_word(plan[i].op, plan[i].count, plan[i].pressed,
                          plan[i].typed, plan[i].want);
            end
        end

        // random sequences under random short settings, with some noise
        while (work_words < RANDOM_WORDS)
        begin
            settle();
            write_reg(REG_HALF_PERIOD, {8'($urandom), 16'($urandom_range(0, 3))});
            write_reg(REG_STEP_GAP,    {8'($urandom), 16'($urandom_range(0, 3))});
            write_reg(REG_STEPS,       {8'($urandom), 16'($urandom_range(0, 4))});
            write_reg(REG_PAUSE,       24'($urandom_range(0, 4)));
            write_reg(REG_RAMP,        24'($urandom_range(0, 5)));
            write_reg(REG_POLL,        24'($urandom_range(0, 4)));
            if ($urandom_range(0, 9) == 0)
            begin
                // ticks and nothing else while idle
                repeat ($urandom_range(3, 8))
                begin
                    send_word(OP_TICK, 16'($urandom), 1'($urandom), 1'b0, '0);
                end
            end
            else
            begin
                // mostly pressed switch, sometimes a flaky one
                run_sequence(16'($urandom_range(0, 3)),
                             ($urandom_range(0, 3) == 0) ? 50 : 15);
            end
        end

        // longest counts that can stay unused: pause, poll and steps at the top
        settle();
        write_reg(REG_PAUSE, 24'hFFFFFF);
        write_reg(REG_POLL,  24'hFFFFFF);
        write_reg(REG_STEPS, 24'hFFFFFF);
        write_reg(REG_RAMP,  24'd2);
        run_sequence(16'd0, 0);

        // short pulse and gap with one step, no idling; the result side
        // holds off early on so the output buffer fills and stalls the input
        settle();
        write_reg(REG_HALF_PERIOD, 24'hFF0020);
        write_reg(REG_STEP_GAP,    24'h000020);
        write_reg(REG_STEPS,       24'd1);
        write_reg(REG_PAUSE,       24'd0);
        write_reg(REG_RAMP,        24'd0);
        write_reg(REG_POLL,        24'd0);
        calm      = 1'b1;
        stall_req = 1'b1;
        run_sequence(16'd1, 10);
        calm = 1'b0;

        settle();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && levels_due.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== sheet_dispense_sequencer.f =====
hw/rtl/sds_pkg.sv
hw/rtl/sds_cfg.sv
hw/rtl/sds_core.sv
hw/rtl/sds_outbuf.sv
hw/rtl/sheet_dispense_sequencer.sv
hw/rtl/sds_checker.sv
verif/tb_sheet_dispense_sequencer.sv
